// ===== hdl/frl_pkg.sv =====
// Shared types, status codes and constants for the filtered recent-id list.
// Used by frl_cell and filtered_recent_id_list_top; depends on nothing else.
package frl_pkg;

   localparam int LIST_ENTRIES = 5;
   localparam int IDENT_W      = 48;
   localparam int STAMP_W      = 64;
   localparam int POS_W        = 3;
   localparam int STATUS_W     = 3;
   localparam int CSR_INDEX_W  = 2;

   localparam logic [STAMP_W-1:0] OLDEST_RESET = 64'd11505369600000000;

   localparam logic CMD_OFFER = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_NOW    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OLDEST = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SINCE  = 2'd2;

   localparam logic [STATUS_W-1:0] ST_INSERTED     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_MOVED        = 3'd1;
   localparam logic [STATUS_W-1:0] ST_REFRESHED    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_NEWER    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_OUT_WINDOW   = 3'd4;
   localparam logic [STATUS_W-1:0] ST_BEFORE_SINCE = 3'd5;
   localparam logic [STATUS_W-1:0] ST_EXCLUDED     = 3'd6;
   localparam logic [STATUS_W-1:0] ST_READ         = 3'd7;

   typedef struct packed {
      logic [IDENT_W-1:0] ident;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

   typedef struct packed {
      logic sample;   // latch the identifier compare for a new request
      logic load;     // apply the list update for the held request
   } cell_ctl_type;

   // Identifiers whose prefix is "H", "JODI" or "SNTE" are dropped.
   function automatic logic is_excluded(input logic [IDENT_W-1:0] id);
      logic h_hit;
      logic jodi_hit;
      logic snte_hit;
      h_hit    = (id[47:40] == 8'h48);
      jodi_hit = (id[47:16] == 32'h4A4F4449);
      snte_hit = (id[47:16] == 32'h534E5445);
      return h_hit | jodi_hit | snte_hit;
   endfunction

endpackage

// ===== hdl/frl_cell.sv =====
// One list slot: holds an identifier and its end time, compares it with the
// incoming request and takes its neighbor's entry on a shift. Uses frl_pkg.
module frl_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  frl_pkg::cell_ctl_type         ctl,
   input  frl_pkg::entry_type            nbr_entry,
   input  logic [frl_pkg::IDENT_W-1:0]   cmp_ident,
   input  logic                          none_above_in,
   output frl_pkg::entry_type            entry,
   output logic                          none_above_out,
   output logic                          first_hit
);
   import frl_pkg::*;

   entry_type entry_ff, entry_in;
   logic      match_ff, match_in;

   always_comb begin
      match_in = ctl.sample ? (entry_ff.ident == cmp_ident) : match_ff;
      // shift only while no slot nearer the head matched
      entry_in = (ctl.load && none_above_in) ? nbr_entry : entry_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
         match_ff <= 1'b0;
      end else begin
         entry_ff <= entry_in;
         match_ff <= match_in;
      end
   end

   assign entry          = entry_ff;
   assign none_above_out = none_above_in & ~match_ff;
   assign first_hit      = none_above_in & match_ff;

endmodule

// ===== hdl/filtered_recent_id_list_top.sv =====
// Flow: an accepted request is captured with its filter results, then its response is registered.
// No new request is taken while one executes or its response is held; the response register
// must drain before the next request, and the cells compare, then update.
// Reset: synchronous; clears every list slot and loads config defaults.
// Top level of the recent-id list; uses frl_pkg and a row of frl_cell.
module filtered_recent_id_list_top #(
   parameter int ENTRIES = frl_pkg::LIST_ENTRIES
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [frl_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [frl_pkg::STAMP_W-1:0]       csr_data,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_cmd,
   input  logic [frl_pkg::IDENT_W-1:0]       req_ident,
   input  logic [frl_pkg::STAMP_W-1:0]       req_finish_time,
   input  logic [frl_pkg::POS_W-1:0]         req_slot,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [frl_pkg::STATUS_W-1:0]      rsp_status,
   output logic [frl_pkg::POS_W-1:0]         rsp_position,
   output logic [frl_pkg::IDENT_W-1:0]       rsp_read_ident,
   output logic [frl_pkg::STAMP_W-1:0]       rsp_read_time
);
   import frl_pkg::*;

   localparam int READ_CELLS = (ENTRIES < 8) ? ENTRIES : 8;
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(ENTRIES - 1);

   logic [STAMP_W-1:0] now_ff, now_in, oldest_ff, oldest_in, since_ff, since_in;

   logic               busy_ff, busy_in;
   logic               cmd_ff, cmd_in;
   logic [IDENT_W-1:0] ident_ff, ident_in;
   logic [STAMP_W-1:0] stamp_ff, stamp_in;
   logic [POS_W-1:0]   slot_ff, slot_in;
   logic               window_ff, window_in;
   logic               since_hit_ff, since_hit_in;
   logic               excl_ff, excl_in;
   logic               older_ff, older_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [IDENT_W-1:0]  rid_ff, rid_in;
   logic [STAMP_W-1:0]  rtime_ff, rtime_in;

   logic         accept, go;
   cell_ctl_type cell_ctl;
   entry_type    entries [ENTRIES];
   logic [ENTRIES:0]   none_above;
   logic [ENTRIES-1:0] first_hit;
   logic [POS_W-1:0]   hit_pos;
   entry_type          read_entry;

   assign req_ready = ~busy_ff & ~rsp_valid_ff;
   assign accept    = req_valid & req_ready;
   assign go        = busy_ff & (cmd_ff == CMD_OFFER) & ~window_ff & ~since_hit_ff
                      & ~excl_ff & ~older_ff;

   assign cell_ctl.sample = accept;
   assign cell_ctl.load   = go;
   assign none_above[0]   = 1'b1;

   // configuration registers
   always_comb begin
      now_in    = now_ff;
      oldest_in = oldest_ff;
      since_in  = since_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_NOW:    now_in    = csr_data;
            CSR_OLDEST: oldest_in = csr_data;
            CSR_SINCE:  since_in  = csr_data;
            default: begin
            end
         endcase
      end
   end

   // capture the request and its filter results
   always_comb begin
      busy_in      = busy_ff;
      cmd_in       = cmd_ff;
      ident_in     = ident_ff;
      stamp_in     = stamp_ff;
      slot_in      = slot_ff;
      window_in    = window_ff;
      since_hit_in = since_hit_ff;
      excl_in      = excl_ff;
      older_in     = older_ff;
      if (accept) begin
         busy_in      = 1'b1;
         cmd_in       = req_cmd;
         ident_in     = req_ident;
         stamp_in     = req_finish_time;
         slot_in      = req_slot;
         window_in    = (req_finish_time > now_ff) || (req_finish_time < oldest_ff);
         since_hit_in = (req_finish_time != '0) && (req_finish_time < since_ff);
         excl_in      = is_excluded(req_ident);
         older_in     = (req_finish_time <= entries[0].stamp);
      end else if (busy_ff) begin
         busy_in = 1'b0;
      end
   end

   genvar g;
   generate
      for (g = 0; g < ENTRIES; g++) begin : g_cell
         entry_type nbr;
         if (g == 0) begin : g_head
            assign nbr.ident = ident_ff;
            assign nbr.stamp = stamp_ff;
         end else begin : g_body
            assign nbr = entries[g-1];
         end
         frl_cell u_cell (
            .clock          (clock),
            .reset          (reset),
            .ctl            (cell_ctl),
            .nbr_entry      (nbr),
            .cmp_ident      (req_ident),
            .none_above_in  (none_above[g]),
            .entry          (entries[g]),
            .none_above_out (none_above[g+1]),
            .first_hit      (first_hit[g])
         );
      end
   endgenerate

   always_comb begin
      hit_pos = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (first_hit[i]) hit_pos = hit_pos | POS_W'(i);
      end
      read_entry = '0;
      for (int i = 0; i < READ_CELLS; i++) begin
         if (slot_ff == POS_W'(i)) read_entry = entries[i];
      end
   end

   // build the response
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      pos_in       = pos_ff;
      rid_in       = rid_ff;
      rtime_in     = rtime_ff;
      if (busy_ff) begin
         rsp_valid_in = 1'b1;
         pos_in       = '0;
         rid_in       = '0;
         rtime_in     = '0;
         priority if (cmd_ff == CMD_READ) begin
            status_in = ST_READ;
            pos_in    = slot_ff;
            rid_in    = read_entry.ident;
            rtime_in  = read_entry.stamp;
         end else if (window_ff) begin
            status_in = ST_OUT_WINDOW;
         end else if (since_hit_ff) begin
            status_in = ST_BEFORE_SINCE;
         end else if (excl_ff) begin
            status_in = ST_EXCLUDED;
         end else if (older_ff) begin
            status_in = ST_NOT_NEWER;
         end else if (first_hit[0]) begin
            status_in = ST_REFRESHED;
         end else if (none_above[ENTRIES]) begin
            status_in = ST_INSERTED;
            pos_in    = LAST_POS;
         end else begin
            status_in = ST_MOVED;
            pos_in    = hit_pos;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff       <= '0;
         oldest_ff    <= OLDEST_RESET;
         since_ff     <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         now_ff       <= now_in;
         oldest_ff    <= oldest_in;
         since_ff     <= since_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      ident_ff     <= ident_in;
      stamp_ff     <= stamp_in;
      slot_ff      <= slot_in;
      window_ff    <= window_in;
      since_hit_ff <= since_hit_in;
      excl_ff      <= excl_in;
      older_ff     <= older_in;
      status_ff    <= status_in;
      pos_ff       <= pos_in;
      rid_ff       <= rid_in;
      rtime_ff     <= rtime_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_position   = pos_ff;
   assign rsp_read_ident = rid_ff;
   assign rsp_read_time  = rtime_ff;

`ifndef SYNTHESIS
   a_one_first_hit: assert property (@(posedge clock) disable iff (reset)
      $onehot0(first_hit))
      else $error("more than one slot flagged as first match");
   a_busy_one_cycle: assert property (@(posedge clock) disable iff (reset)
      busy_ff |=> !busy_ff && rsp_valid_ff)
      else $error("request not completed in one execute cycle");
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(busy_ff))
      else $error("response raised without a request in flight");
   a_no_accept_pending: assert property (@(posedge clock) disable iff (reset)
      accept |-> !rsp_valid_ff && !busy_ff)
      else $error("request accepted while a response is pending");
`endif

endmodule

// ===== tb/sv/filtered_recent_id_list_top_tb.sv =====
// Self-checking testbench for filtered_recent_id_list_top: directed and random requests,
// checked against a shadow copy of the recency list kept in a small scoreboard class.
// Depends on frl_pkg and filtered_recent_id_list_top only.
`timescale 1ns / 100ps

module filtered_recent_id_list_top_tb;
   import frl_pkg::*;

   localparam int CLOCK_PERIOD  = 10;
   localparam int CYCLE_LIMIT   = 300000;
   localparam int SETTLE_CYCLES = 8;
   localparam int LONG_HOLD     = 400;
   localparam int POOL_SIZE     = 6;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   localparam logic [STAMP_W-1:0] WINDOW_OPEN  = OLDEST_RESET + 64'd1000;
   localparam logic [STAMP_W-1:0] WINDOW_CLOSE = OLDEST_RESET + 64'h1_0000_0000_0000;

   localparam logic [IDENT_W-1:0] ID_ALPHA   = "ALPHA1";
   localparam logic [IDENT_W-1:0] ID_BRAVO   = "BRAVO2";
   localparam logic [IDENT_W-1:0] ID_CHARLIE = "CHARL3";
   localparam logic [IDENT_W-1:0] ID_NEAR    = "JODX42";
   localparam logic [IDENT_W-1:0] ID_HOTEL   = "HOTEL1";
   localparam logic [IDENT_W-1:0] ID_JODI    = "JODI42";
   localparam logic [IDENT_W-1:0] ID_SNTE    = "SNTE07";

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [POS_W-1:0]    position;
      logic [IDENT_W-1:0]  ident;
      logic [STAMP_W-1:0]  stamp;
   } response_type;

   // Shadow of the recency list: predicts one response per request.
   class recent_list_shadow;
      logic [STAMP_W-1:0] now_t;
      logic [STAMP_W-1:0] oldest_t;
      logic [STAMP_W-1:0] since_t;
      logic [IDENT_W-1:0] ids [LIST_ENTRIES];
      logic [STAMP_W-1:0] stamps [LIST_ENTRIES];
      response_type       due_responses [$];
      int                 mismatches;

      function new();
         now_t      = '0;
         oldest_t   = OLDEST_RESET;
         since_t    = '0;
         mismatches = 0;
         foreach (ids[k]) begin
            ids[k]    = '0;
            stamps[k] = '0;
         end
      endfunction

      function void set_register(logic [CSR_INDEX_W-1:0] index, logic [STAMP_W-1:0] value);
         unique case (index)
            CSR_NOW: begin
               now_t = value;
            end
            CSR_OLDEST: begin
               oldest_t = value;
            end
            CSR_SINCE: begin
               since_t = value;
            end
            default: begin
            end
         endcase
      endfunction

      function bit blocked_prefix(logic [IDENT_W-1:0] id);
         return id[47:40] == "H" || id[47:16] == "JODI" || id[47:16] == "SNTE";
      endfunction

      function void take_request(logic cmd, logic [IDENT_W-1:0] id,
                                 logic [STAMP_W-1:0] t, logic [POS_W-1:0] slot);
         response_type r;
         int hit;
         int k;
         r   = '{default: '0};
         hit = LIST_ENTRIES;
         if (cmd == CMD_READ) begin
            r.status   = ST_READ;
            r.position = slot;
            if (slot < LIST_ENTRIES) begin
               r.ident = ids[slot];
               r.stamp = stamps[slot];
            end
         end else if (t > now_t || t < oldest_t) begin
            r.status = ST_OUT_WINDOW;
         end else if (t != '0 && t < since_t) begin
            r.status = ST_BEFORE_SINCE;
         end else if (blocked_prefix(id)) begin
            r.status = ST_EXCLUDED;
         end else if (t <= stamps[0]) begin
            r.status = ST_NOT_NEWER;
         end else begin
            // first matching slot wins, so an empty slot matches identifier zero
            for (k = LIST_ENTRIES - 1; k >= 0; k--) begin
               if (ids[k] == id) hit = k;
            end
            if (hit == 0) begin
               stamps[0] = t;
               r.status  = ST_REFRESHED;
            end else begin
               if (hit < LIST_ENTRIES) begin
                  r.status = ST_MOVED;
               end else begin
                  r.status = ST_INSERTED;
                  hit      = LIST_ENTRIES - 1;
               end
               r.position = POS_W'(hit);
               for (k = hit; k > 0; k--) begin
                  ids[k]    = ids[k-1];
                  stamps[k] = stamps[k-1];
               end
               ids[0]    = id;
               stamps[0] = t;
            end
         end
         due_responses.push_back(r);
      endfunction

      function void match_response(logic [STATUS_W-1:0] status, logic [POS_W-1:0] position,
                                   logic [IDENT_W-1:0] id, logic [STAMP_W-1:0] t);
         response_type want;
         if (due_responses.size() == 0) begin
            $error("unexpected response: status %0d position %0d", status, position);
            mismatches++;
            return;
         end
         want = due_responses.pop_front();
         if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            mismatches++;
         end
         if (position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, position);
            mismatches++;
         end
         if (id !== want.ident) begin
            $error("read_ident: expected %h, got %h", want.ident, id);
            mismatches++;
         end
         if (t !== want.stamp) begin
            $error("read_time: expected %h, got %h", want.stamp, t);
            mismatches++;
         end
      endfunction

      function int outstanding();
         return due_responses.size();
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [STAMP_W-1:0]     csr_data;
   logic                   req_valid;
   logic                   req_ready;
   logic                   req_cmd;
   logic [IDENT_W-1:0]     req_ident;
   logic [STAMP_W-1:0]     req_finish_time;
   logic [POS_W-1:0]       req_slot;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [STATUS_W-1:0]    rsp_status;
   logic [POS_W-1:0]       rsp_position;
   logic [IDENT_W-1:0]     rsp_read_ident;
   logic [STAMP_W-1:0]     rsp_read_time;

   recent_list_shadow  shadow;
   logic [STAMP_W-1:0] cfg_now;
   logic [STAMP_W-1:0] cfg_oldest;
   logic [STAMP_W-1:0] cfg_since;
   logic [STAMP_W-1:0] stamp_cursor;
   logic [IDENT_W-1:0] id_pool [POOL_SIZE];
   bit                 no_idle;
   bit                 hold_request;
   int                 stall_left;
   int                 cycle_count;

   filtered_recent_id_list_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_ident       (req_ident),
      .req_finish_time (req_finish_time),
      .req_slot        (req_slot),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_position    (rsp_position),
      .rsp_read_ident  (rsp_read_ident),
      .rsp_read_time   (rsp_read_time)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Check the response first so a request taken at the same edge cannot hide it.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            shadow.match_response(rsp_status, rsp_position, rsp_read_ident, rsp_read_time);
         end
         if (req_valid && req_ready) begin
            shadow.take_request(req_cmd, req_ident, req_finish_time, req_slot);
         end
      end
   end

   // Response side: draw a stall after each accepted response, or one long hold on demand.
   always @(posedge clock) begin
      int pause;
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else if (rsp_valid && rsp_ready) begin
         if (hold_request) begin
            pause = LONG_HOLD;
            hold_request <= 1'b0;
         end else begin
            pause = no_idle ? 0 : $urandom_range(0, 5);
         end
         if (pause != 0) begin
            rsp_ready  <= 1'b0;
            stall_left <= pause;
         end
      end else if (!rsp_ready) begin
         if (stall_left <= 1) rsp_ready <= 1'b1;
         stall_left <= stall_left - 1;
      end
   end

   function automatic logic [IDENT_W-1:0] random_ident();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[IDENT_W-1:0];
   endfunction

   function automatic logic [STAMP_W-1:0] random_stamp();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [IDENT_W-1:0] pick_ident();
      int                 r;
      logic [IDENT_W-1:0] tail;
      r    = $urandom_range(0, 99);
      tail = random_ident();
      if (r < 3) return '0;
      if (r < 70) return id_pool[$urandom_range(0, POOL_SIZE - 1)];
      if (r < 80) return tail;
      if (r < 84) return {"H", tail[39:0]};
      if (r < 88) return {"JODI", tail[15:0]};
      if (r < 92) return {"SNTE", tail[15:0]};
      // near misses of the excluded prefixes
      if (r < 96) return {"JOD", tail[23:0]};
      return {"SNT", tail[23:0]};
   endfunction

   // Mostly advance the cursor so records keep getting newer than the head.
   function automatic logic [STAMP_W-1:0] pick_stamp();
      int                 r;
      logic [STAMP_W-1:0] stride;
      r      = $urandom_range(0, 99);
      stride = STAMP_W'($urandom_range(1, 5000));
      if (r < 72) begin
         if (cfg_now >= stamp_cursor && cfg_now - stamp_cursor > stride) begin
            stamp_cursor = stamp_cursor + stride;
         end else begin
            stamp_cursor = cfg_now;
         end
         return stamp_cursor;
      end
      if (r < 84) return stamp_cursor - stride;
      if (r < 90) return random_stamp();
      if (r < 94) return cfg_now + stride;
      if (r < 97) return cfg_oldest - stride;
      if (r < 99) return cfg_since - stride;
      return '0;
   endfunction

   task automatic offer(input logic cmd, input logic [IDENT_W-1:0] id,
                        input logic [STAMP_W-1:0] t, input logic [POS_W-1:0] slot);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_ident       <= id;
      req_finish_time <= t;
      req_slot        <= slot;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic random_requests(input int count);
      int n;
      for (n = 0; n < count; n++) begin
         if (n % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 99) < 15) begin
            offer(CMD_READ, random_ident(), random_stamp(), POS_W'($urandom_range(0, 7)));
         end else begin
            offer(CMD_OFFER, pick_ident(), pick_stamp(), POS_W'($urandom_range(0, 7)));
         end
      end
      no_idle = 1'b0;
   endtask

   // Drop valid, let the last accepted request reach the shadow, then wait it out.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (shadow.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write every register, the unused index included; only called while idle.
   task automatic program_window(input logic [STAMP_W-1:0] now_v,
                                 input logic [STAMP_W-1:0] oldest_v,
                                 input logic [STAMP_W-1:0] since_v);
      logic [STAMP_W-1:0] junk;
      junk = random_stamp();
      csr_write_en <= 1'b1;
      csr_index    <= CSR_NOW;
      csr_data     <= now_v;
      @(posedge clock);
      csr_index <= CSR_OLDEST;
      csr_data  <= oldest_v;
      @(posedge clock);
      csr_index <= CSR_SINCE;
      csr_data  <= since_v;
      @(posedge clock);
      csr_index <= CSR_SPARE;
      csr_data  <= junk;
      @(posedge clock);
      csr_write_en <= 1'b0;
      shadow.set_register(CSR_NOW, now_v);
      shadow.set_register(CSR_OLDEST, oldest_v);
      shadow.set_register(CSR_SINCE, since_v);
      shadow.set_register(CSR_SPARE, junk);
      cfg_now    = now_v;
      cfg_oldest = oldest_v;
      cfg_since  = since_v;
   endtask

   initial begin
      logic [IDENT_W-1:0] noise;
      int                 s;
      shadow          = new();
      cycle_count     = 0;
      no_idle         = 1'b0;
      hold_request    = 1'b0;
      reset           = 1'b1;
      csr_write_en    = 1'b0;
      csr_index       = '0;
      csr_data        = '0;
      req_valid       = 1'b0;
      req_cmd         = CMD_OFFER;
      req_ident       = '0;
      req_finish_time = '0;
      req_slot        = '0;
      rsp_ready       = 1'b0;
      cfg_now         = '0;
      cfg_oldest      = OLDEST_RESET;
      cfg_since       = '0;
      for (s = 0; s < POOL_SIZE; s++) begin
         noise      = random_ident();
         id_pool[s] = {8'h41 + 8'(s), noise[39:0]};
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // The reset window is empty: everything falls outside it.
      offer(CMD_OFFER, ID_ALPHA, '0, '0);
      offer(CMD_OFFER, ID_ALPHA, '1, '0);
      settle();

      program_window(WINDOW_CLOSE, OLDEST_RESET, WINDOW_OPEN);
      offer(CMD_OFFER, ID_ALPHA, OLDEST_RESET, '0);
      offer(CMD_OFFER, ID_ALPHA, OLDEST_RESET - 64'd1, '0);
      offer(CMD_OFFER, ID_ALPHA, WINDOW_CLOSE + 64'd1, '0);
      offer(CMD_OFFER, ID_HOTEL, WINDOW_OPEN + 64'd5, '0);
      offer(CMD_OFFER, ID_JODI, WINDOW_OPEN + 64'd5, '0);
      offer(CMD_OFFER, ID_SNTE, WINDOW_OPEN + 64'd5, '0);
      // identifier zero hits the empty head, then an empty slot further down
      offer(CMD_OFFER, '0, WINDOW_OPEN, '0);
      offer(CMD_OFFER, ID_ALPHA, WINDOW_OPEN + 64'd1, '0);
      offer(CMD_OFFER, '0, WINDOW_OPEN + 64'd2, '0);
      offer(CMD_OFFER, ID_NEAR, WINDOW_OPEN + 64'd3, '0);
      offer(CMD_OFFER, ID_BRAVO, WINDOW_OPEN + 64'd4, '0);
      offer(CMD_OFFER, ID_CHARLIE, WINDOW_OPEN + 64'd5, '0);
      offer(CMD_OFFER, ID_ALPHA, WINDOW_OPEN + 64'd6, '0);
      offer(CMD_OFFER, ID_ALPHA, WINDOW_OPEN + 64'd7, '0);
      offer(CMD_OFFER, ID_BRAVO, WINDOW_OPEN + 64'd7, '0);
      for (s = 0; s < 8; s++) begin
         offer(CMD_READ, random_ident(), random_stamp(), POS_W'(s));
      end
      stamp_cursor = WINDOW_OPEN + 64'd8;
      random_requests(500);
      settle();

      program_window(OLDEST_RESET + 64'h1000_0000_0000, '0, '0);
      random_requests(400);
      settle();

      // Wide window with a late since time; hold responses off to back up the input.
      program_window('1, '0, ~64'hF_FFFF);
      stamp_cursor = ~64'hF_FFFF;
      hold_request = 1'b1;
      random_requests(350);
      settle();

      program_window('1, '1, '1);
      stamp_cursor = '1;
      offer(CMD_OFFER, ID_ALPHA, '0, '0);
      random_requests(200);
      settle();

      if (shadow.mismatches == 0 && shadow.outstanding() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
